[sv/otb_pkg.sv]
// shared types and codes for the outline to bezier segment block
// no dependencies
package otb_pkg;

	localparam int OUT_COORD_BITS = 32;
	localparam int SEG_SLOTS = 3;
	localparam int SLOT_BITS = 2;
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	typedef enum logic [1:0] {
		SEG_LINE  = 2'd0,
		SEG_QUAD  = 2'd1,
		SEG_CUBIC = 2'd2,
		SEG_ERROR = 2'd3
	} seg_kind_t;

	typedef enum logic [1:0] {
		TAG_CONIC    = 2'd0,
		TAG_ON       = 2'd1,
		TAG_CUBIC    = 2'd2,
		TAG_RESERVED = 2'd3
	} tag_t;

	// coordinate order: from x/y, first ctrl x/y, second ctrl x/y, to x/y
	typedef struct packed {
		seg_kind_t kind;
		logic [7:0][OUT_COORD_BITS-1:0] c;
	} seg_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0] cnt;
		seg_t [SEG_SLOTS-1:0] seg;
	} bundle_t;

endpackage

[sv/otb_front.sv]
// front end: accepts outline points, tracks contour state, builds segment bundles
// depends on otb_pkg
module otb_front #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,
	input  logic [2:0] s_tuser,
	input  logic s_tlast,
	output logic push_valid,
	input  logic push_ready,
	output otb_pkg::bundle_t push_data
);
	import otb_pkg::*;

	localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;

	typedef enum logic [1:0] {
		PEND_NONE   = 2'd0,
		PEND_CONIC  = 2'd1,
		PEND_CUBIC1 = 2'd2,
		PEND_CUBIC2 = 2'd3
	} pend_t;

	logic [CW-1:0] start_x_q, start_y_q, pen_x_q, pen_y_q;
	logic [CW-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
	pend_t pend_q;
	logic first_q, abort_q;

	logic [CW-1:0] x, y;
	tag_t tag;
	logic ce, ge, err, bv, cv, accept;
	logic [CW-1:0] n_start_x, n_start_y, n_pen_x, n_pen_y;
	logic [CW-1:0] n_a_x, n_a_y, n_b_x, n_b_y, mid_x, mid_y;
	logic signed [CW:0] sum_x, sum_y, adj_x, adj_y;
	pend_t n_pend;
	seg_t bseg, cseg, lseg;
	bundle_t bundle;
	logic [SLOT_BITS-1:0] k;

	function automatic seg_t mk(input seg_kind_t kd,
		input logic [CW-1:0] fx, input logic [CW-1:0] fy,
		input logic [CW-1:0] ax, input logic [CW-1:0] ay,
		input logic [CW-1:0] bx, input logic [CW-1:0] by,
		input logic [CW-1:0] tx, input logic [CW-1:0] ty);
		seg_t s;
		s.kind = kd;
		s.c[0] = OUT_COORD_BITS'($signed(fx));
		s.c[1] = OUT_COORD_BITS'($signed(fy));
		s.c[2] = OUT_COORD_BITS'($signed(ax));
		s.c[3] = OUT_COORD_BITS'($signed(ay));
		s.c[4] = OUT_COORD_BITS'($signed(bx));
		s.c[5] = OUT_COORD_BITS'($signed(by));
		s.c[6] = OUT_COORD_BITS'($signed(tx));
		s.c[7] = OUT_COORD_BITS'($signed(ty));
		return s;
	endfunction

	assign x = s_tdata[CW-1:0];
	assign y = s_tdata[32+CW-1:32];
	assign tag = tag_t'(s_tuser[1:0]);
	assign ge = s_tlast;
	assign ce = s_tuser[2] | s_tlast;

	// conic midpoint, sum halved with truncation toward zero
	assign sum_x = $signed({a_x_q[CW-1], a_x_q}) + $signed({x[CW-1], x});
	assign sum_y = $signed({a_y_q[CW-1], a_y_q}) + $signed({y[CW-1], y});
	assign adj_x = sum_x + $signed({{CW{1'b0}}, sum_x[CW]});
	assign adj_y = sum_y + $signed({{CW{1'b0}}, sum_y[CW]});
	assign mid_x = adj_x[CW:1];
	assign mid_y = adj_y[CW:1];

	always_comb begin
		err = 1'b0;
		bv = 1'b0;
		bseg = '0;
		n_start_x = start_x_q;
		n_start_y = start_y_q;
		n_pen_x = pen_x_q;
		n_pen_y = pen_y_q;
		n_a_x = a_x_q;
		n_a_y = a_y_q;
		n_b_x = b_x_q;
		n_b_y = b_y_q;
		n_pend = pend_q;
		if (first_q) begin
			n_start_x = x;
			n_start_y = y;
			n_pen_x = x;
			n_pen_y = y;
			n_pend = PEND_NONE;
		end else begin
			case (pend_q)
				PEND_NONE: begin
					if (tag == TAG_ON) begin
						bv = 1'b1;
						bseg = mk(SEG_LINE, pen_x_q, pen_y_q, '0, '0, '0, '0, x, y);
						n_pen_x = x;
						n_pen_y = y;
					end else if (tag == TAG_CONIC) begin
						n_a_x = x;
						n_a_y = y;
						n_pend = PEND_CONIC;
					end else if (ce) begin
						err = 1'b1;
					end else begin
						n_a_x = x;
						n_a_y = y;
						n_pend = PEND_CUBIC1;
					end
				end
				PEND_CONIC: begin
					if (tag == TAG_ON) begin
						bv = 1'b1;
						bseg = mk(SEG_QUAD, pen_x_q, pen_y_q, a_x_q, a_y_q, '0, '0, x, y);
						n_pen_x = x;
						n_pen_y = y;
						n_pend = PEND_NONE;
					end else if (tag == TAG_CONIC) begin
						bv = 1'b1;
						bseg = mk(SEG_QUAD, pen_x_q, pen_y_q, a_x_q, a_y_q, '0, '0,
							mid_x, mid_y);
						n_pen_x = mid_x;
						n_pen_y = mid_y;
						n_a_x = x;
						n_a_y = y;
					end else begin
						err = 1'b1;
					end
				end
				PEND_CUBIC1: begin
					if (tag == TAG_CUBIC) begin
						n_b_x = x;
						n_b_y = y;
						n_pend = PEND_CUBIC2;
					end else begin
						err = 1'b1;
					end
				end
				default: begin
					bv = 1'b1;
					bseg = mk(SEG_CUBIC, pen_x_q, pen_y_q, a_x_q, a_y_q, b_x_q, b_y_q, x, y);
					n_pen_x = x;
					n_pen_y = y;
					n_pend = PEND_NONE;
				end
			endcase
		end

		// contour close: pending curve to the start, then the closing line
		cv = 1'b0;
		cseg = '0;
		if (n_pend == PEND_CONIC) begin
			cv = ce;
			cseg = mk(SEG_QUAD, n_pen_x, n_pen_y, n_a_x, n_a_y, '0, '0,
				n_start_x, n_start_y);
		end else if (n_pend == PEND_CUBIC2) begin
			cv = ce;
			cseg = mk(SEG_CUBIC, n_pen_x, n_pen_y, n_a_x, n_a_y, n_b_x, n_b_y,
				n_start_x, n_start_y);
		end
		if (cv) begin
			lseg = mk(SEG_LINE, n_start_x, n_start_y, '0, '0, '0, '0, n_start_x, n_start_y);
		end else begin
			lseg = mk(SEG_LINE, n_pen_x, n_pen_y, '0, '0, '0, '0, n_start_x, n_start_y);
		end

		bundle = '0;
		k = '0;
		if (err) begin
			bundle.seg[0].kind = SEG_ERROR;
			k = SLOT_BITS'(1);
		end else begin
			if (bv) begin
				bundle.seg[k] = bseg;
				k = k + SLOT_BITS'(1);
			end
			if (cv) begin
				bundle.seg[k] = cseg;
				k = k + SLOT_BITS'(1);
			end
			if (ce) begin
				bundle.seg[k] = lseg;
				k = k + SLOT_BITS'(1);
			end
		end
		bundle.cnt = k;
	end

	// an item with no segment is taken without a queue slot
	assign s_tready = push_ready;
	assign accept = s_tvalid & s_tready;
	assign push_valid = s_tvalid & ~abort_q & (k != '0);
	assign push_data = bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			pen_x_q <= '0;
			pen_y_q <= '0;
			a_x_q <= '0;
			a_y_q <= '0;
			b_x_q <= '0;
			b_y_q <= '0;
			pend_q <= PEND_NONE;
			first_q <= 1'b1;
			abort_q <= 1'b0;
		end else if (accept) begin
			if (abort_q || err) begin
				if (ge) begin
					pend_q <= PEND_NONE;
					first_q <= 1'b1;
					abort_q <= 1'b0;
				end else begin
					abort_q <= 1'b1;
				end
			end else begin
				start_x_q <= n_start_x;
				start_y_q <= n_start_y;
				a_x_q <= n_a_x;
				a_y_q <= n_a_y;
				b_x_q <= n_b_x;
				b_y_q <= n_b_y;
				if (ce) begin
					pen_x_q <= n_start_x;
					pen_y_q <= n_start_y;
					pend_q <= PEND_NONE;
					first_q <= 1'b1;
				end else begin
					pen_x_q <= n_pen_x;
					pen_y_q <= n_pen_y;
					pend_q <= n_pend;
					first_q <= 1'b0;
				end
			end
		end
	end

endmodule

[sv/otb_queue.sv]
// small bundle queue between the front end and the segment drain
// depends on otb_pkg
module otb_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  otb_pkg::bundle_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output otb_pkg::bundle_t pop_data
);
	import otb_pkg::*;

	bundle_t entry_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != QCNT_BITS'(QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign push = push_valid & push_ready;
	assign pop = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

[sv/otb_back.sv]
// back end: drains queued bundles one segment per cycle, while m_tready allows, into the output register
// depends on otb_pkg
module otb_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  otb_pkg::bundle_t q_data,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [255:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic m_tlast
);
	import otb_pkg::*;

	logic [SLOT_BITS-1:0] idx_q;
	logic load, last_slot;
	seg_t cur;

	assign load = ~m_tvalid | m_tready;
	assign cur = q_data.seg[idx_q];
	assign last_slot = (idx_q == q_data.cnt - SLOT_BITS'(1));
	assign q_ready = load & last_slot;

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			m_tdata <= cur.c;
			m_tuser <= cur.kind;
			m_tlast <= last_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			m_tvalid <= q_valid;
			if (q_valid) begin
				idx_q <= last_slot ? '0 : idx_q + SLOT_BITS'(1);
			end
		end
	end

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> q_data.cnt != '0)
		else $error("queued bundle without segments");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> idx_q < q_data.cnt)
		else $error("slot index past bundle count");

	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == SEG_ERROR |-> m_tlast)
		else $error("error segment not last of its item");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> idx_q == '0)
		else $error("slot index left mid bundle with empty queue");

endmodule

[sv/outline_to_bezier_segments_top.sv]
// a point's first segment passes through a queue entry and then the output register after the point is accepted
// points are taken one per cycle while each yields at most one segment and the output is not stalled;
//   a point yielding several segments holds the output register for each of them, absorbed by a 4-bundle queue
// points yielding no segment take no queue slot, but wait like any other point while it is full
// reset (arst_n low) clears contour state, queue pointers and output valid at once
module outline_to_bezier_segments_top #(
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,   // point_x, point_y
	input  logic [2:0] s_tuser,    // tag, contour_end
	input  logic s_tlast,          // glyph_end
	output logic m_tvalid,
	input  logic m_tready,
	// from_x, from_y, first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y, to_x, to_y
	output logic [255:0] m_tdata,
	output logic [1:0] m_tuser,    // segment_kind
	output logic m_tlast           // run_last
);
	import otb_pkg::*;

	// front to queue
	logic push_valid, push_ready;
	bundle_t push_data;
	// queue to back
	logic pop_valid, pop_ready;
	bundle_t pop_data;

	// front: point classification, pen and contour tracking, midpoints
	otb_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	// decouples point intake from the segment drain
	otb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	// back: one segment per cycle, while m_tready allows, through the output register
	otb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(pop_valid),
		.q_ready(pop_ready),
		.q_data(pop_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

[test/otb_segment_checker.sv]
`timescale 1ns / 100ps
// checker for the outline to bezier segment block: predicts segments from accepted points
// and compares them field by field with the output stream; depends on otb_pkg only

module otb_segment_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [63:0] s_tdata,   // point_x, point_y
	input  logic [2:0] s_tuser,    // tag, contour_end
	input  logic s_tlast,          // glyph_end
	input  logic m_tvalid,
	input  logic m_tready,
	// from_x, from_y, first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y, to_x, to_y
	input  logic [255:0] m_tdata,
	input  logic [1:0] m_tuser,    // segment_kind
	input  logic m_tlast,          // run_last
	output int mismatches,
	output int points_in,
	output int points_used,
	output int segs_seen,
	output int pending_segs
);
	import otb_pkg::*;

	typedef logic signed [31:0] crd_t;
	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_CONIC,
		PEND_CUBIC1,
		PEND_CUBIC2
	} pend_t;
	typedef struct packed {
		seg_kind_t kind;
		logic [7:0][31:0] crd;
		logic last;
	} seg_exp_t;

	seg_exp_t expected_segs[$];
	seg_exp_t run_segs[$];
	crd_t start_x, start_y, pen_x, pen_y;
	crd_t ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y;
	pend_t pend;
	bit opening, skipping;
	int n_bad = 0;
	int n_in = 0;
	int n_used = 0;
	int n_segs = 0;

	function automatic string crd_label(input int i);
		case (i)
			0: return "from_x";
			1: return "from_y";
			2: return "first_ctrl_x";
			3: return "first_ctrl_y";
			4: return "second_ctrl_x";
			5: return "second_ctrl_y";
			6: return "to_x";
			default: return "to_y";
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want, got);
		if (n_bad < 40)
			$display("%0t ns: segment %0d %s: expected %h, got %h", $time, n_segs, what, want, got);
		n_bad++;
	endtask

	task automatic start_glyph();
		pend = PEND_NONE;
		opening = 1'b1;
		skipping = 1'b0;
	endtask

	task automatic add_seg(input seg_kind_t k, input crd_t fx, fy, c1x, c1y, c2x, c2y, tx, ty);
		seg_exp_t s;
		s.kind = k;
		s.crd = {ty, tx, c2y, c2x, c1y, c1x, fy, fx};
		s.last = 1'b0;
		run_segs.push_back(s);
	endtask

	// segments caused by one accepted point, appended to the expected stream
	task automatic predict_segments(input crd_t px, py, input tag_t tg, input bit ce_in, ge);
		bit ce, bad;
		longint sum_x, sum_y;
		crd_t mid_x, mid_y;
		seg_exp_t s;
		ce = ce_in | ge;
		bad = 1'b0;
		run_segs.delete();
		n_in++;
		if (skipping) begin
			if (ge)
				start_glyph();
			return;
		end
		n_used++;

		if (opening) begin
			start_x = px;
			start_y = py;
			pen_x = px;
			pen_y = py;
			pend = PEND_NONE;
			opening = 1'b0;
		end else begin
			case (pend)
				PEND_NONE: begin
					if (tg == TAG_ON) begin
						add_seg(SEG_LINE, pen_x, pen_y, 0, 0, 0, 0, px, py);
						pen_x = px;
						pen_y = py;
					end else if (tg == TAG_CONIC) begin
						ctrl_a_x = px;
						ctrl_a_y = py;
						pend = PEND_CONIC;
					end else if (ce) begin
						bad = 1'b1;
					end else begin
						ctrl_a_x = px;
						ctrl_a_y = py;
						pend = PEND_CUBIC1;
					end
				end
				PEND_CONIC: begin
					if (tg == TAG_ON) begin
						add_seg(SEG_QUAD, pen_x, pen_y, ctrl_a_x, ctrl_a_y, 0, 0, px, py);
						pen_x = px;
						pen_y = py;
						pend = PEND_NONE;
					end else if (tg == TAG_CONIC) begin
						// implied on-curve midpoint, halved toward zero
						sum_x = longint'(ctrl_a_x) + longint'(px);
						sum_y = longint'(ctrl_a_y) + longint'(py);
						mid_x = crd_t'(sum_x / 2);
						mid_y = crd_t'(sum_y / 2);
						add_seg(SEG_QUAD, pen_x, pen_y, ctrl_a_x, ctrl_a_y, 0, 0, mid_x, mid_y);
						pen_x = mid_x;
						pen_y = mid_y;
						ctrl_a_x = px;
						ctrl_a_y = py;
					end else begin
						bad = 1'b1;
					end
				end
				PEND_CUBIC1: begin
					if (tg == TAG_CUBIC) begin
						ctrl_b_x = px;
						ctrl_b_y = py;
						pend = PEND_CUBIC2;
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					add_seg(SEG_CUBIC, pen_x, pen_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, px, py);
					pen_x = px;
					pen_y = py;
					pend = PEND_NONE;
				end
			endcase
		end

		if (bad) begin
			run_segs.delete();
			add_seg(SEG_ERROR, 0, 0, 0, 0, 0, 0, 0, 0);
			if (ge)
				start_glyph();
			else
				skipping = 1'b1;
		end else begin
			if (ce) begin
				if (pend == PEND_CONIC)
					add_seg(SEG_QUAD, pen_x, pen_y, ctrl_a_x, ctrl_a_y, 0, 0, start_x, start_y);
				else if (pend == PEND_CUBIC2)
					add_seg(SEG_CUBIC, pen_x, pen_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
						start_x, start_y);
				if (pend == PEND_CONIC || pend == PEND_CUBIC2) begin
					pen_x = start_x;
					pen_y = start_y;
				end
				// closing line, zero length when the pen is already home
				add_seg(SEG_LINE, pen_x, pen_y, 0, 0, 0, 0, start_x, start_y);
				pen_x = start_x;
				pen_y = start_y;
				pend = PEND_NONE;
				opening = 1'b1;
			end
			if (ge)
				start_glyph();
		end

		if (run_segs.size() > 0) begin
			s = run_segs.pop_back();
			s.last = 1'b1;
			run_segs.push_back(s);
		end
		foreach (run_segs[i])
			expected_segs.push_back(run_segs[i]);
	endtask

	task automatic check_segment();
		seg_exp_t want;
		logic [31:0] got;
		n_segs++;
		if (expected_segs.size() == 0) begin
			report_mismatch("arrived with nothing expected, kind", 32'd0, {30'd0, m_tuser});
			return;
		end
		want = expected_segs.pop_front();
		if (m_tuser !== want.kind)
			report_mismatch("segment_kind", {30'd0, want.kind}, {30'd0, m_tuser});
		for (int i = 0; i < 8; i++) begin
			got = m_tdata[32*i +: 32];
			if (got !== want.crd[i])
				report_mismatch(crd_label(i), want.crd[i], got);
		end
		if (m_tlast !== want.last)
			report_mismatch("run_last", {31'd0, want.last}, {31'd0, m_tlast});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x = 0;
			start_y = 0;
			pen_x = 0;
			pen_y = 0;
			ctrl_a_x = 0;
			ctrl_a_y = 0;
			ctrl_b_x = 0;
			ctrl_b_y = 0;
			start_glyph();
			expected_segs.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_segment();
			if (s_tvalid && s_tready)
				predict_segments(s_tdata[31:0], s_tdata[63:32], tag_t'(s_tuser[1:0]),
					s_tuser[2], s_tlast);
		end
		mismatches <= n_bad;
		points_in <= n_in;
		points_used <= n_used;
		segs_seen <= n_segs;
		pending_segs <= expected_segs.size();
	end

endmodule

[test/tb_outline_to_bezier_segments_top.sv]
`timescale 1ns / 100ps
// testbench top for outline_to_bezier_segments_top: drives outline points, throttles the
// segment output and gives the verdict; depends on the top, otb_pkg and otb_segment_checker

module tb_outline_to_bezier_segments_top;
	import otb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;     // settle margin after the drain
	localparam int POINT_TARGET = 190;
	localparam int LONG_HOLD = 150;
	localparam logic [31:0] CRD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] CRD_MIN = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;   // point_x, point_y
	logic [2:0] s_tuser = '0;    // tag, contour_end
	logic s_tlast = 1'b0;        // glyph_end
	logic m_tvalid;
	logic m_tready = 1'b0;
	// from_x, from_y, first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y, to_x, to_y
	logic [255:0] m_tdata;
	logic [1:0] m_tuser;         // segment_kind
	logic m_tlast;               // run_last

	int mismatches, points_in, points_used, segs_seen, pending_segs;
	int cycles = 0;
	int sent = 0;
	int send_mood = 0;
	bit long_hold_done = 1'b0;

	outline_to_bezier_segments_top #(
		.COORD_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	otb_segment_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches),
		.points_in(points_in),
		.points_used(points_used),
		.segs_seen(segs_seen),
		.pending_segs(pending_segs)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// segment receiver: moods of no stall, light stall and heavy stall, plus one long
	// hold-off once the run is under way so the internal queue fills and s_tready drops
	initial begin
		int mood, k, span;
		mood = 0;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			span++;
			if (span % 50 == 0)
				mood = $urandom_range(0, 2);
			if (!long_hold_done && points_in >= 60) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else if (mood != 0 && $urandom_range(0, 99) < (mood == 1 ? 10 : 35)) begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
				m_tready <= 1'b0;
				repeat (k - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// mostly small coordinates, some fully random, some at the extremes
	function automatic logic [31:0] pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(0, 4000) - 2000;
		if (r < 85)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return CRD_MIN;
			1: return CRD_MAX;
			2: return 32'd0;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (send_mood == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one point and hold it until taken, then maybe leave a gap
	task automatic send_point(input logic [31:0] px, py, input tag_t tg, input bit ce, ge);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		s_tuser <= {ce, tg};
		s_tlast <= ge;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		if (sent % 40 == 0)
			send_mood = $urandom_range(0, 2);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering until every predicted segment has come out
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_segs != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a well-formed glyph of one to three contours with random content, or, when
	// noisy, random tags and contour marks that mostly end in an error
	task automatic send_glyph(input bit noisy);
		int contour_cnt, n_pts, r, mode;
		bit last, ce, ge;
		tag_t tg;
		if (noisy) begin
			n_pts = $urandom_range(1, 12);
			for (int i = 0; i < n_pts; i++)
				send_point(pick_coord(), pick_coord(), tag_t'($urandom_range(0, 3)),
					$urandom_range(0, 3) == 0, i == n_pts - 1);
			return;
		end
		contour_cnt = $urandom_range(1, 3);
		for (int c = 0; c < contour_cnt; c++) begin
			n_pts = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
			mode = 0;  // 0 nothing pending, 1 conic, 2 one cubic control, 3 two
			for (int i = 0; i < n_pts; i++) begin
				last = (i == n_pts - 1);
				r = $urandom_range(0, 9);
				if (i == 0) begin
					tg = tag_t'($urandom_range(0, 3));
				end else begin
					case (mode)
						0: begin
							if (r < 4) begin
								tg = TAG_ON;
							end else if (r < 7) begin
								tg = TAG_CONIC;
								mode = 1;
							end else if (!last) begin
								tg = (r == 9) ? TAG_RESERVED : TAG_CUBIC;
								mode = 2;
							end else begin
								tg = TAG_ON;
							end
						end
						1: begin
							if (r < 5) begin
								tg = TAG_ON;
								mode = 0;
							end else begin
								tg = TAG_CONIC;
							end
						end
						2: begin
							tg = TAG_CUBIC;
							mode = 3;
						end
						default: begin
							// any tag ends a cubic
							tg = tag_t'($urandom_range(0, 3));
							mode = 0;
						end
					endcase
				end
				ge = last && (c == contour_cnt - 1);
				ce = last && !(ge && $urandom_range(0, 3) == 0);
				send_point(pick_coord(), pick_coord(), tg, ce, ge);
			end
		end
	endtask

	initial begin
		int glyphs;
		glyphs = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, straight line between them, then conic runs with implied midpoints
		// (odd negative sums check truncation toward zero) and a pending conic closed
		send_point(CRD_MAX, CRD_MIN, TAG_ON, 1'b0, 1'b0);
		send_point(CRD_MIN, CRD_MAX, TAG_ON, 1'b0, 1'b0);
		send_point(-32'sd3, 32'sd5, TAG_CONIC, 1'b0, 1'b0);
		send_point(-32'sd4, -32'sd6, TAG_CONIC, 1'b0, 1'b0);
		send_point(CRD_MAX, CRD_MIN, TAG_CONIC, 1'b1, 1'b0);
		// single-point contour opened by a cubic tag
		send_point(32'd10, 32'd10, TAG_CUBIC, 1'b1, 1'b0);
		// reserved tag starting a cubic, a cubic ended by a conic tag, then a cubic pair
		// pending at the contour end
		send_point(32'd1, 32'd1, TAG_ON, 1'b0, 1'b0);
		send_point(32'd2, 32'd2, TAG_RESERVED, 1'b0, 1'b0);
		send_point(32'd3, 32'd3, TAG_CUBIC, 1'b0, 1'b0);
		send_point(32'd4, 32'd4, TAG_CONIC, 1'b0, 1'b0);
		send_point(32'd5, 32'd5, TAG_CUBIC, 1'b0, 1'b0);
		send_point(32'd6, 32'd6, TAG_CUBIC, 1'b1, 1'b0);
		// glyph end without contour end on a lone point
		send_point(32'hffff_ffff, 32'd0, TAG_ON, 1'b0, 1'b1);
		// cubic control not followed by another: error, rest of glyph ignored
		send_point(32'd0, 32'd0, TAG_ON, 1'b0, 1'b0);
		send_point(32'd1, 32'd0, TAG_CUBIC, 1'b0, 1'b0);
		send_point(32'd2, 32'd0, TAG_ON, 1'b0, 1'b0);
		send_point(32'd3, 32'd0, TAG_ON, 1'b1, 1'b0);
		send_point(32'd4, 32'd0, TAG_ON, 1'b0, 1'b1);
		// truncated cubic on the glyph end point itself
		send_point(32'd0, 32'd0, TAG_ON, 1'b0, 1'b0);
		send_point(32'd1, 32'd1, TAG_CUBIC, 1'b1, 1'b1);
		// conic followed by reserved tag, on the glyph end
		send_point(32'd0, 32'd0, TAG_ON, 1'b0, 1'b0);
		send_point(32'd1, 32'd1, TAG_CONIC, 1'b0, 1'b0);
		send_point(32'd2, 32'd2, TAG_RESERVED, 1'b0, 1'b1);
		// conic followed by cubic, then reserved tag as second cubic control
		send_point(32'd0, 32'd0, TAG_ON, 1'b0, 1'b0);
		send_point(32'd1, 32'd1, TAG_CONIC, 1'b0, 1'b0);
		send_point(32'd2, 32'd2, TAG_CUBIC, 1'b0, 1'b1);
		send_point(32'd0, 32'd0, TAG_ON, 1'b0, 1'b0);
		send_point(32'd1, 32'd1, TAG_CUBIC, 1'b0, 1'b0);
		send_point(32'd2, 32'd2, TAG_RESERVED, 1'b0, 1'b1);
		wait_quiet();

		// random glyphs, mostly well formed; one more full drain part way through
		while (sent < POINT_TARGET) begin
			send_glyph($urandom_range(0, 99) < 15);
			glyphs++;
			if (glyphs == 12)
				wait_quiet();
		end
		wait_quiet();

		$display("run covered %0d points (%0d outside aborted glyphs) in %0d random glyphs,",
			points_in, points_used, glyphs);
		$display("%0d segments checked, with a %0d-cycle output hold-off and full drains",
			segs_seen, LONG_HOLD);
		if (mismatches == 0 && pending_segs == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
